>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/tct_pkg.sv
// Package: thermistor code table, widths and helper types
`default_nettype none
package tct_pkg;
  localparam int TableEntries = 140;
  localparam int IdxW  = 8;
  localparam int CodeW = 10;
  localparam int TempW = 12;
  // 140 entries can take nine narrowing steps before the interval closes
  localparam int SearchSteps = 9;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [IdxW-1:0]  idx_t;

  // Search state carried through the pipeline
  typedef struct packed {
    logic  vld;
    logic  done;
    code_t code;
    idx_t  lo;
    idx_t  hi;
    idx_t  idx;
  } srch_t;

  function automatic code_t rom_at(input idx_t i);
    code_t r;
    unique case (i)
      8'd0: r=10'd951; 8'd1: r=10'd947; 8'd2: r=10'd943; 8'd3: r=10'd939;
      8'd4: r=10'd934; 8'd5: r=10'd930; 8'd6: r=10'd925; 8'd7: r=10'd920;
      8'd8: r=10'd915; 8'd9: r=10'd909; 8'd10: r=10'd904; 8'd11: r=10'd898;
      8'd12: r=10'd892; 8'd13: r=10'd886; 8'd14: r=10'd880; 8'd15: r=10'd873;
      8'd16: r=10'd866; 8'd17: r=10'd860; 8'd18: r=10'd852; 8'd19: r=10'd845;
      8'd20: r=10'd838; 8'd21: r=10'd830; 8'd22: r=10'd822; 8'd23: r=10'd815;
      8'd24: r=10'd806; 8'd25: r=10'd798; 8'd26: r=10'd790; 8'd27: r=10'd781;
      8'd28: r=10'd772; 8'd29: r=10'd763; 8'd30: r=10'd754; 8'd31: r=10'd745;
      8'd32: r=10'd736; 8'd33: r=10'd727; 8'd34: r=10'd717; 8'd35: r=10'd707;
      8'd36: r=10'd698; 8'd37: r=10'd688; 8'd38: r=10'd678; 8'd39: r=10'd668;
      8'd40: r=10'd658; 8'd41: r=10'd648; 8'd42: r=10'd638; 8'd43: r=10'd628;
      8'd44: r=10'd618; 8'd45: r=10'd607; 8'd46: r=10'd597; 8'd47: r=10'd587;
      8'd48: r=10'd577; 8'd49: r=10'd567; 8'd50: r=10'd557; 8'd51: r=10'd546;
      8'd52: r=10'd536; 8'd53: r=10'd526; 8'd54: r=10'd516; 8'd55: r=10'd507;
      8'd56: r=10'd497; 8'd57: r=10'd487; 8'd58: r=10'd477; 8'd59: r=10'd468;
      8'd60: r=10'd458; 8'd61: r=10'd449; 8'd62: r=10'd440; 8'd63: r=10'd430;
      8'd64: r=10'd421; 8'd65: r=10'd412; 8'd66: r=10'd404; 8'd67: r=10'd395;
      8'd68: r=10'd386; 8'd69: r=10'd378; 8'd70: r=10'd370; 8'd71: r=10'd361;
      8'd72: r=10'd353; 8'd73: r=10'd345; 8'd74: r=10'd338; 8'd75: r=10'd330;
      8'd76: r=10'd323; 8'd77: r=10'd315; 8'd78: r=10'd308; 8'd79: r=10'd301;
      8'd80: r=10'd294; 8'd81: r=10'd287; 8'd82: r=10'd280; 8'd83: r=10'd274;
      8'd84: r=10'd267; 8'd85: r=10'd261; 8'd86: r=10'd255; 8'd87: r=10'd249;
      8'd88: r=10'd243; 8'd89: r=10'd237; 8'd90: r=10'd232; 8'd91: r=10'd226;
      8'd92: r=10'd221; 8'd93: r=10'd216; 8'd94: r=10'd211; 8'd95: r=10'd206;
      8'd96: r=10'd201; 8'd97: r=10'd196; 8'd98: r=10'd191; 8'd99: r=10'd187;
      8'd100: r=10'd182; 8'd101: r=10'd178; 8'd102: r=10'd174; 8'd103: r=10'd170;
      8'd104: r=10'd166; 8'd105: r=10'd162; 8'd106: r=10'd158; 8'd107: r=10'd154;
      8'd108: r=10'd151; 8'd109: r=10'd147; 8'd110: r=10'd144; 8'd111: r=10'd140;
      8'd112: r=10'd137; 8'd113: r=10'd134; 8'd114: r=10'd131; 8'd115: r=10'd128;
      8'd116: r=10'd125; 8'd117: r=10'd122; 8'd118: r=10'd119; 8'd119: r=10'd116;
      8'd120: r=10'd114; 8'd121: r=10'd111; 8'd122: r=10'd109; 8'd123: r=10'd106;
      8'd124: r=10'd104; 8'd125: r=10'd101; 8'd126: r=10'd99; 8'd127: r=10'd97;
      8'd128: r=10'd95; 8'd129: r=10'd93; 8'd130: r=10'd90; 8'd131: r=10'd88;
      8'd132: r=10'd86; 8'd133: r=10'd85; 8'd134: r=10'd83; 8'd135: r=10'd81;
      8'd136: r=10'd79; 8'd137: r=10'd77; 8'd138: r=10'd76; 8'd139: r=10'd74;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/tct_search_stage.sv
// One binary-search step of the table lookup, registered
`default_nettype none
module tct_search_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire tct_pkg::srch_t s_in,
  output tct_pkg::srch_t     s_out
);
  tct_pkg::srch_t s_r, s_nxt;
  tct_pkg::idx_t  mid;
  tct_pkg::code_t ent;

  // One narrowing step; a finished search passes through
  always_comb begin
    s_nxt = s_in;
    mid   = tct_pkg::idx_t'((9'(s_in.lo) + 9'(s_in.hi)) >> 1);
    ent   = tct_pkg::rom_at(mid);
    if (!s_in.done) begin
      if (s_in.lo >= s_in.hi) begin
        s_nxt.done = 1'b1;
      end else if (s_in.code == ent) begin
        s_nxt.idx = mid; s_nxt.done = 1'b1;
      end else if (s_in.hi - s_in.lo == 8'd1) begin
        s_nxt.idx = s_in.lo; s_nxt.done = 1'b1;
      end else if (s_in.code < ent) begin
        s_nxt.lo = mid; s_nxt.idx = mid;
      end else begin
        s_nxt.hi = mid; s_nxt.idx = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r.vld <= s_in.vld;
    end
    if (en) begin
      s_r.done <= s_nxt.done; s_r.code <= s_nxt.code;
      s_r.lo <= s_nxt.lo; s_r.hi <= s_nxt.hi; s_r.idx <= s_nxt.idx;
    end
  end
  assign s_out = s_r;
endmodule
`default_nettype wire

>>> rtl/core/tct_interp.sv
// Interpolation: span fetch, restoring divide, scale and saturate
`default_nettype none
module tct_interp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire tct_pkg::code_t  code,
  input  wire tct_pkg::idx_t   idx,
  input  wire logic [7:0]      offset,
  output logic                 out_vld,
  output logic signed [11:0]   temp
);
  localparam int NumW = 15;  // |10*(T[i]-code)| <= 10230
  localparam int DenW = 10;
  localparam int Last = tct_pkg::TableEntries - 1;

  // Stage A: fetch entries, form numerator magnitude and sign
  logic            a_vld_r;
  logic            a_neg_r;
  logic [NumW-1:0] a_num_r;
  logic [DenW-1:0] a_den_r;
  logic signed [9:0] a_base_r;
  tct_pkg::idx_t   lo_i, hi_i;
  logic signed [11:0] diff;
  logic [NumW-1:0] mag;
  always_comb begin
    lo_i = (idx == tct_pkg::idx_t'(Last)) ? idx - 8'd1 : idx;
    hi_i = lo_i + 8'd1;
    diff = $signed({2'b00, tct_pkg::rom_at(idx)}) - $signed({2'b00, code});
    mag  = diff[11] ? NumW'(-diff) : NumW'(diff);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_vld;
    if (en) begin
      a_neg_r  <= diff[11];
      a_num_r  <= (mag << 3) + (mag << 1);
      a_den_r  <= tct_pkg::rom_at(lo_i) - tct_pkg::rom_at(hi_i);
      a_base_r <= $signed({2'b00, idx}) - $signed({2'b00, offset});
    end
  end

  // Divide stages: 15 quotient bits, 5 bits per stage
  localparam int NDiv = 3;
  localparam int BitsPer = 5;
  logic            d_vld_r [NDiv];
  logic            d_neg_r [NDiv];
  logic [NumW-1:0] d_q_r   [NDiv];
  logic [DenW:0]   d_rem_r [NDiv];
  logic [DenW-1:0] d_den_r [NDiv];
  logic signed [9:0] d_base_r [NDiv];

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    logic [NumW-1:0] q_in, q_nxt;
    logic [DenW:0]   r_in, r_nxt;
    logic [DenW-1:0] dn;
    logic [DenW+1:0] trial;
    logic            v_in, n_in;
    logic signed [9:0] b_in;

    // Stage inputs: stage A feeds the first, each later one takes the previous
    if (g == 0) begin : g_head
      assign q_in = a_num_r;
      assign r_in = '0;
      assign dn   = a_den_r;
      assign v_in = a_vld_r;
      assign n_in = a_neg_r;
      assign b_in = a_base_r;
    end else begin : g_tail
      assign q_in = d_q_r[g-1];
      assign r_in = d_rem_r[g-1];
      assign dn   = d_den_r[g-1];
      assign v_in = d_vld_r[g-1];
      assign n_in = d_neg_r[g-1];
      assign b_in = d_base_r[g-1];
    end

    always_comb begin
      q_nxt = q_in; r_nxt = r_in; trial = '0;
      for (int b = 0; b < BitsPer; b++) begin
        trial = {r_nxt, q_nxt[NumW-1]};
        q_nxt = q_nxt << 1;
        if (trial >= {2'b00, dn}) begin
          trial = trial - {2'b00, dn};
          q_nxt[0] = 1'b1;
        end
        r_nxt = trial[DenW:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d_vld_r[g] <= 1'b0;
      else if (en) d_vld_r[g] <= v_in;
      if (en) begin
        d_q_r[g]    <= q_nxt;
        d_rem_r[g]  <= r_nxt;
        d_den_r[g]  <= dn;
        d_neg_r[g]  <= n_in;
        d_base_r[g] <= b_in;
      end
    end
  end

  // Final stage: sign, scale, add, saturate
  logic signed [15:0] frac, sum;
  logic signed [13:0] base10;
  logic             o_vld_r;
  logic signed [11:0] o_temp_r;
  always_comb begin
    frac   = (d_den_r[NDiv-1] == '0) ? 16'sd0 :
             (d_neg_r[NDiv-1] ? -$signed({1'b0, d_q_r[NDiv-1]})
                              :  $signed({1'b0, d_q_r[NDiv-1]}));
    // widen before scaling; offsets up to 255 give -2550
    base10 = 14'(d_base_r[NDiv-1]) * 14'sd10;
    sum    = frac + 16'(base10);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= d_vld_r[NDiv-1];
    if (en) begin
      if (sum < -16'sd2048) o_temp_r <= -12'sd2048;
      else if (sum > 16'sd2047) o_temp_r <= 12'sd2047;
      else o_temp_r <= sum[11:0];
    end
  end
  assign out_vld = o_vld_r;
  assign temp    = o_temp_r;
endmodule
`default_nettype wire

>>> rtl/core/thermistor_code_to_temperature.sv
// Depth from in item accepted to out_tvalid: 9 search, 5 interp stages.
// Throughput: one item per cycle unless stalled; a table-search step per stage.
// Whole pipeline advances when the output register is empty or being taken.
// Reset (rst_n, sync, active low) clears valid bits; degree_offset goes to 40.
// Config writes are always accepted; write only when the pipeline is empty.
`default_nettype none
`include "assert_macros.svh"
module thermistor_code_to_temperature (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [9:0] adc_code
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [11:0] temperature_tenths
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data    // degree_offset
);
  localparam int N = tct_pkg::SearchSteps;
  logic       en;
  logic [7:0] offset_r;
  tct_pkg::srch_t s [N+1];
  logic       iv;
  logic signed [11:0] temp;

  // Stall everything when the output holds an item not taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) offset_r <= 8'd40;
    else if (cfg_valid) offset_r <= cfg_data;
  end

  // Search chain entry
  always_comb begin
    s[0].vld  = in_tvalid;
    s[0].done = 1'b0;
    s[0].code = in_tdata[9:0];
    s[0].lo   = '0;
    s[0].hi   = tct_pkg::idx_t'(tct_pkg::TableEntries - 1);
    s[0].idx  = '0;
  end

  for (genvar g = 0; g < N; g++) begin : g_srch
    tct_search_stage u_stage (.clk(clk), .rst_n(rst_n), .en(en),
                              .s_in(s[g]), .s_out(s[g+1]));
  end

  tct_interp u_interp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s[N].vld),
    .code(s[N].code), .idx(s[N].idx), .offset(offset_r),
    .out_vld(iv), .temp(temp)
  );

  assign out_tvalid = iv;
  assign out_tdata  = {4'b0000, temp};

  `ASSERT_CLK(a_search_done, clk, rst_n, !s[N].vld || s[N].done, "search unfinished at end")
  `ASSERT_CLK(a_idx_range, clk, rst_n, !s[N].vld || s[N].idx < 8'd139, "index out of range")
  `ASSERT_CLK(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> $stable(out_tdata), "output changed while stalled")
endmodule
`default_nettype wire
